@@ rtl/core/msp_pkg.sv @@
// msp_pkg: shared types, codes and the control element size table of the
// mac subheader parser. No dependencies; imported by every module of the block but msp_fifo.
`default_nettype none

package msp_pkg;

	// id at and above which a subheader is a control element
	localparam logic [4:0]  CE_ID_MIN     = 5'd26;
	// saturation value of the consumed byte count
	localparam logic [16:0] CONSUMED_MAX  = 17'h1FFFF;

	// config register indexes
	localparam logic [1:0]  REG_LINK_ADDR = 2'd0;

	// payload of one accepted input transaction
	typedef struct packed {
		logic [7:0]  header_byte;
		logic        pdu_start;
		logic [15:0] pdu_length;
	} in_item_t;

	// payload of one result transaction
	typedef struct packed {
		logic [4:0]  channel_id;
		logic [15:0] payload_length;
		logic        is_control;
		logic        is_final;
		logic        length_error;
	} out_item_t;

	// front parser phase
	typedef enum logic [1:0] {
		PH_FIRST,
		PH_LEN1,
		PH_LEN2,
		PH_DONE
	} phase_t;

	// kind of work handed from front to back
	typedef enum logic [1:0] {
		OP_NONE,
		OP_SDU,
		OP_CE,
		OP_FINAL
	} op_t;

	// one classified record in the front-to-back queue
	typedef struct packed {
		op_t         op;
		logic        start;
		logic [15:0] pdu_length;
		logic [4:0]  channel_id;
		logic [14:0] sdu_length;
		logic        long_hdr;
	} mid_rec_t;

	// fixed control element size from id and link direction
	function automatic logic [2:0] ce_size(input logic [4:0] id, input logic uplink);
		logic [2:0] sz;
		sz = 3'd0;
		if (uplink) begin
			case (id)
				5'd26:   sz = 3'd1;
				5'd27:   sz = 3'd2;
				5'd28:   sz = 3'd1;
				5'd29:   sz = 3'd1;
				5'd30:   sz = 3'd3;
				default: sz = 3'd0;
			endcase
		end else begin
			case (id)
				5'd28:   sz = 3'd6;
				5'd29:   sz = 3'd1;
				default: sz = 3'd0;
			endcase
		end
		return sz;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/msp_fifo.sv @@
// msp_fifo: small show-ahead register queue, used between front and back
// and in front of the result port. No package dependency.
`default_nettype none

module msp_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_en,
	input  wire logic [W-1:0] wr_data,
	output logic              full,
	input  wire logic         rd_en,
	output logic [W-1:0]      rd_data,
	output logic              empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]  slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(DEPTH))
		else $error("fifo count beyond depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (count_q == $past(count_q) + 1'b1))
		else $error("fifo count did not follow write");

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(full && empty))
		else $error("fifo full and empty at once");

endmodule

`default_nettype wire

@@ rtl/core/msp_front.sv @@
// msp_front: byte-level subheader parser; splits header bytes into E/LCID
// and F/L fields and issues one classified record per event. Uses msp_pkg.
`default_nettype none

module msp_front
	import msp_pkg::*;
#(
	parameter int MAX_SUBHEADERS = 32
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     take,
	input  wire in_item_t item,
	output logic          rec_push,
	output mid_rec_t      rec
);

	phase_t      phase_q, phase_d;
	logic [4:0]  held_id_q, held_id_d;
	logic [6:0]  held_len_q, held_len_d;
	logic [5:0]  count_q, count_d;

	phase_t      phase_eff;
	logic [5:0]  count_eff;
	logic        ext;
	logic        last;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_FIRST;
			held_id_q  <= '0;
			held_len_q <= '0;
			count_q    <= '0;
		end else if (take) begin
			phase_q    <= phase_d;
			held_id_q  <= held_id_d;
			held_len_q <= held_len_d;
			count_q    <= count_d;
		end
	end

	// next phase and record
	always_comb begin
		phase_eff  = item.pdu_start ? PH_FIRST : phase_q;
		count_eff  = item.pdu_start ? 6'd0 : count_q;
		ext        = item.header_byte[5];
		last       = !ext || ({1'b0, count_eff} + 7'd1 >= 7'(MAX_SUBHEADERS));
		phase_d    = phase_eff;
		held_id_d  = held_id_q;
		held_len_d = held_len_q;
		count_d    = count_eff;

		rec.op         = OP_NONE;
		rec.start      = item.pdu_start;
		rec.pdu_length = item.pdu_length;
		rec.channel_id = item.header_byte[4:0];
		rec.sdu_length = {8'd0, item.header_byte[6:0]};
		rec.long_hdr   = 1'b0;

		unique case (phase_eff)
			PH_FIRST: begin
				if (last) begin
					rec.op  = OP_FINAL;
					count_d = count_eff + 6'd1;
					phase_d = PH_DONE;
				end else if (item.header_byte[4:0] >= CE_ID_MIN) begin
					rec.op  = OP_CE;
					count_d = count_eff + 6'd1;
				end else begin
					held_id_d = item.header_byte[4:0];
					phase_d   = PH_LEN1;
				end
			end
			PH_LEN1: begin
				rec.channel_id = held_id_q;
				held_len_d     = item.header_byte[6:0];
				if (item.header_byte[7]) begin
					phase_d = PH_LEN2;
				end else begin
					rec.op  = OP_SDU;
					count_d = count_eff + 6'd1;
					phase_d = PH_FIRST;
				end
			end
			PH_LEN2: begin
				rec.op         = OP_SDU;
				rec.channel_id = held_id_q;
				rec.sdu_length = {held_len_q, item.header_byte};
				rec.long_hdr   = 1'b1;
				count_d        = count_eff + 6'd1;
				phase_d        = PH_FIRST;
			end
			PH_DONE: begin
				rec.op = OP_NONE;
			end
			default: begin
				phase_d = PH_FIRST;
			end
		endcase

		rec_push = take && ((rec.op != OP_NONE) || item.pdu_start);
	end

	a_len2_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !item.pdu_start && phase_q == PH_LEN2) |=> (phase_q == PH_FIRST))
		else $error("long length octet did not end subheader");

	a_final_done: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_push && rec.op == OP_FINAL) |=> (phase_q == PH_DONE))
		else $error("final subheader did not close the pdu");

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !item.pdu_start && phase_q == PH_DONE) |-> !rec_push)
		else $error("record issued after final subheader");

endmodule

`default_nettype wire

@@ rtl/core/msp_back.sv @@
// msp_back: executes classified records; keeps the consumed byte count and
// the latched pdu length and forms result transactions. Uses msp_pkg.
`default_nettype none

module msp_back
	import msp_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     link_is_uplink,
	input  wire logic     rec_valid,
	input  wire mid_rec_t rec,
	output logic          rec_take,
	input  wire logic     res_full,
	output logic          res_push,
	output out_item_t     res
);

	logic [16:0] consumed_q;
	logic [15:0] plen_q;

	logic [16:0] base_cons;
	logic [15:0] base_plen;
	logic [2:0]  ce_sz;
	logic [15:0] add_amt;
	logic [17:0] sum;
	logic [17:0] need;
	logic [16:0] next_cons;
	logic        err;

	// record execution
	always_comb begin
		rec_take  = rec_valid && !res_full;
		base_cons = rec.start ? 17'd0 : consumed_q;
		base_plen = rec.start ? rec.pdu_length : plen_q;
		ce_sz     = ce_size(rec.channel_id, link_is_uplink);
		add_amt   = 16'd0;
		need      = {1'b0, base_cons} + 18'd1;
		err       = 1'b0;

		res.channel_id     = rec.channel_id;
		res.payload_length = 16'd0;
		res.is_control     = (rec.channel_id >= CE_ID_MIN);
		res.is_final       = 1'b0;
		res.length_error   = 1'b0;

		case (rec.op)
			OP_SDU: begin
				add_amt            = {1'b0, rec.sdu_length} + (rec.long_hdr ? 16'd3 : 16'd2);
				res.payload_length = {1'b0, rec.sdu_length};
			end
			OP_CE: begin
				add_amt            = 16'(ce_sz) + 16'd1;
				res.payload_length = 16'(ce_sz);
			end
			OP_FINAL: begin
				err                = (need > {2'b0, base_plen});
				res.is_final       = 1'b1;
				res.length_error   = err;
				res.payload_length = err ? 16'd0 : base_plen - need[15:0];
			end
			default: begin
				add_amt = 16'd0;
			end
		endcase

		sum       = {1'b0, base_cons} + {2'b0, add_amt};
		next_cons = (sum > {1'b0, CONSUMED_MAX}) ? CONSUMED_MAX : sum[16:0];
		res_push  = rec_take && (rec.op != OP_NONE);
	end

	// running pdu state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			consumed_q <= '0;
			plen_q     <= '0;
		end else if (rec_take) begin
			consumed_q <= (rec.op == OP_SDU || rec.op == OP_CE) ? next_cons : base_cons;
			plen_q     <= base_plen;
		end
	end

	a_err_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (!res.length_error || res.is_final))
		else $error("length error on non-final result");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_take && rec.start && rec.op == OP_FINAL) |=> (consumed_q == 17'd0))
		else $error("consumed count not cleared by pdu start");

	a_err_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.length_error) |-> (res.payload_length == 16'd0))
		else $error("length error with nonzero payload length");

endmodule

`default_nettype wire

@@ rtl/core/mac_subheader_parser_top.sv @@
// mac_subheader_parser_top: mac pdu subheader parser, front parser and back
// executor joined by a record queue, result queue at the output.
// Depends on msp_pkg, msp_fifo, msp_front, msp_back.
//
// channel   handshake                  payload
// header    push / full                in_item_t  (header_byte, pdu_start, pdu_length)
// result    pop / empty                out_item_t (channel_id .. length_error)
// config    psel penable pwrite pready link_is_uplink at paddr 0, bit 0 of pwdata
//
// one header byte per cycle sustained while the record queue is not full; a
// result reaches the port through the record queue and then the result queue
// after the byte that completes its subheader
// reset clears parser phase, counts, latched length, queues and the config bit
// a stalled result side fills the result queue, then the record queue; full
// rises only when the record queue holds MID_DEPTH records
`default_nettype none

module mac_subheader_parser_top
	import msp_pkg::*;
#(
	parameter int MAX_SUBHEADERS = 32,
	parameter int MID_DEPTH      = 4,
	parameter int OUT_DEPTH      = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// header byte queue side
	input  wire logic        push,
	output logic             full,
	input  wire in_item_t    header,
	// result queue side
	output logic             empty,
	input  wire logic        pop,
	output out_item_t        result,
	// config port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int REC_W = $bits(mid_rec_t);
	localparam int RES_W = $bits(out_item_t);

	logic       uplink_q;
	logic       take;
	logic       rec_push;
	mid_rec_t   rec_in;
	mid_rec_t   rec_out;
	logic       mid_full;
	logic       mid_empty;
	logic       rec_take;
	logic       res_full;
	logic       res_push;
	out_item_t  res_in;

	// config register
	assign pready = 1'b1;
	assign prdata = (paddr == REG_LINK_ADDR) ? {31'd0, uplink_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uplink_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr == REG_LINK_ADDR) begin
			uplink_q <= pwdata[0];
		end
	end

	// input transaction
	assign full = mid_full;
	assign take = push && !mid_full;

	msp_front #(
		.MAX_SUBHEADERS(MAX_SUBHEADERS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.item     (header),
		.rec_push (rec_push),
		.rec      (rec_in)
	);

	// front to back record queue
	msp_fifo #(
		.W     (REC_W),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rec_push),
		.wr_data (rec_in),
		.full    (mid_full),
		.rd_en   (rec_take),
		.rd_data (rec_out),
		.empty   (mid_empty)
	);

	msp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.link_is_uplink (uplink_q),
		.rec_valid      (!mid_empty),
		.rec            (rec_out),
		.rec_take       (rec_take),
		.res_full       (res_full),
		.res_push       (res_push),
		.res            (res_in)
	);

	// result queue
	msp_fifo #(
		.W     (RES_W),
		.DEPTH (OUT_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty)
	);

	a_no_lost_rec: assert property (@(posedge clk) disable iff (!arst_n)
		!(rec_push && mid_full))
		else $error("record pushed into full queue");

	a_no_lost_res: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_push && res_full))
		else $error("result pushed into full queue");

	a_err_final: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.length_error) |-> result.is_final)
		else $error("length error shown on non-final result");

endmodule

`default_nettype wire
